FILE: hw/rtl/tslpg_pkg.sv
// ----------------------------------------------------------------------------
// Touch pattern generator package
// Shared widths, register indexes and waveform tables.
// ----------------------------------------------------------------------------
package tslpg_pkg;

    localparam int DUTY_W = 10;
    localparam int PAT_W  = 4;
    localparam int HOLD_W = 7;
    localparam int THR_W  = 16;
    localparam int STEP_W = 31;
    localparam int SEED_W = 16;
    localparam int FLK_W  = 8;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TOUCH_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS      = 8'd1;

    localparam logic [THR_W-1:0]  THR_RESET  = 16'd2000;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 7'd100;
    localparam logic [SEED_W-1:0] SEED_RESET = 16'd13;
    localparam logic [FLK_W-1:0]  FLK_RESET  = 8'd100;

    localparam logic [PAT_W-1:0] PAT_SINE    = 4'd0;
    localparam logic [PAT_W-1:0] PAT_HEART   = 4'd1;
    localparam logic [PAT_W-1:0] PAT_TRI     = 4'd2;
    localparam logic [PAT_W-1:0] PAT_FLAME   = 4'd3;
    localparam logic [PAT_W-1:0] PAT_TRIPLE  = 4'd4;
    localparam logic [PAT_W-1:0] PAT_LONG    = 4'd5;
    localparam logic [PAT_W-1:0] PAT_HALFSAW = 4'd6;
    localparam logic [PAT_W-1:0] PAT_CONST   = 4'd7;
    localparam logic [PAT_W-1:0] PAT_SLOWTRI = 4'd8;

    typedef struct packed {
        logic             cmd;
        logic [THR_W-1:0] tally;
    } t_item;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [PAT_W-1:0]  pattern;
        logic              touched;
    } t_result;

    function automatic logic [DUTY_W-1:0] sine_lut(input logic [7:0] a);
        logic [DUTY_W-1:0] t [256];
        t = '{
        10'h1f4,10'h200,10'h20c,10'h218,10'h224,10'h231,10'h23d,10'h249,
        10'h255,10'h261,10'h26d,10'h279,10'h284,10'h290,10'h29c,10'h2a7,
        10'h2b3,10'h2be,10'h2c9,10'h2d4,10'h2df,10'h2ea,10'h2f4,10'h2ff,
        10'h309,10'h313,10'h31d,10'h327,10'h330,10'h33a,10'h343,10'h34c,
        10'h355,10'h35d,10'h366,10'h36e,10'h376,10'h37d,10'h385,10'h38c,
        10'h393,10'h39a,10'h3a0,10'h3a6,10'h3ac,10'h3b2,10'h3b7,10'h3bc,
        10'h3c1,10'h3c6,10'h3ca,10'h3ce,10'h3d1,10'h3d5,10'h3d8,10'h3db,
        10'h3dd,10'h3e0,10'h3e2,10'h3e3,10'h3e5,10'h3e6,10'h3e6,10'h3e7,
        10'h3e7,10'h3e7,10'h3e6,10'h3e6,10'h3e5,10'h3e3,10'h3e2,10'h3e0,
        10'h3dd,10'h3db,10'h3d8,10'h3d5,10'h3d1,10'h3ce,10'h3ca,10'h3c6,
        10'h3c1,10'h3bc,10'h3b7,10'h3b2,10'h3ac,10'h3a6,10'h3a0,10'h39a,
        10'h393,10'h38c,10'h385,10'h37d,10'h376,10'h36e,10'h366,10'h35d,
        10'h355,10'h34c,10'h343,10'h33a,10'h330,10'h327,10'h31d,10'h313,
        10'h309,10'h2ff,10'h2f4,10'h2ea,10'h2df,10'h2d4,10'h2c9,10'h2be,
        10'h2b3,10'h2a7,10'h29c,10'h290,10'h284,10'h279,10'h26d,10'h261,
        10'h255,10'h249,10'h23d,10'h231,10'h224,10'h218,10'h20c,10'h200,
        10'h1f4,10'h1e7,10'h1db,10'h1cf,10'h1c3,10'h1b6,10'h1aa,10'h19e,
        10'h192,10'h186,10'h17a,10'h16e,10'h163,10'h157,10'h14b,10'h140,
        10'h134,10'h129,10'h11e,10'h113,10'h108,10'h0fd,10'h0f3,10'h0e8,
        10'h0de,10'h0d4,10'h0ca,10'h0c0,10'h0b7,10'h0ad,10'h0a4,10'h09b,
        10'h092,10'h08a,10'h081,10'h079,10'h071,10'h06a,10'h062,10'h05b,
        10'h054,10'h04d,10'h047,10'h041,10'h03b,10'h035,10'h030,10'h02b,
        10'h026,10'h021,10'h01d,10'h019,10'h016,10'h012,10'h00f,10'h00c,
        10'h00a,10'h007,10'h005,10'h004,10'h002,10'h001,10'h001,10'h000,
        10'h000,10'h000,10'h001,10'h001,10'h002,10'h004,10'h005,10'h007,
        10'h00a,10'h00c,10'h00f,10'h012,10'h016,10'h019,10'h01d,10'h021,
        10'h026,10'h02b,10'h030,10'h035,10'h03b,10'h041,10'h047,10'h04d,
        10'h054,10'h05b,10'h062,10'h06a,10'h071,10'h079,10'h081,10'h08a,
        10'h092,10'h09b,10'h0a4,10'h0ad,10'h0b7,10'h0c0,10'h0ca,10'h0d4,
        10'h0de,10'h0e8,10'h0f3,10'h0fd,10'h108,10'h113,10'h11e,10'h129,
        10'h134,10'h140,10'h14b,10'h157,10'h163,10'h16e,10'h17a,10'h186,
        10'h192,10'h19e,10'h1aa,10'h1b6,10'h1c3,10'h1cf,10'h1db,10'h1e7};
        return t[a];
    endfunction

    // Entries past the listed beats of the heart shape are dark.
    function automatic logic [DUTY_W-1:0] heart_lut(input logic [5:0] a);
        logic [DUTY_W-1:0] d;
        case (a)
            6'd0:  d = 10'd500;  6'd1:  d = 10'd990;  6'd2:  d = 10'd700;
            6'd3:  d = 10'd500;  6'd4:  d = 10'd300;  6'd5:  d = 10'd100;
            6'd6:  d = 10'd200;  6'd7:  d = 10'd600;  6'd8:  d = 10'd990;
            6'd9:  d = 10'd700;  6'd10: d = 10'd500;  6'd11: d = 10'd400;
            6'd12: d = 10'd300;  6'd13: d = 10'd250;  6'd14: d = 10'd200;
            6'd15: d = 10'd150;  6'd16: d = 10'd100;  6'd17: d = 10'd50;
            default: d = '0;
        endcase
        return d;
    endfunction

    // Up ramp over 21 entries, then the mirror image.
    function automatic logic [DUTY_W-1:0] tri_lut(input logic [5:0] a);
        logic [DUTY_W-1:0] d;
        if (a <= 6'd19) begin
            d = 10'(a * 50);
        end else if (a <= 6'd21) begin
            d = 10'd999;
        end else begin
            d = 10'((6'd41 - a) * 50);
        end
        return d;
    endfunction

    function automatic logic [DUTY_W-1:0] halfsaw_lut(input logic [5:0] a);
        logic [5:0] k;
        k = (a >= 6'd21) ? a - 6'd21 : a;
        return (k == 6'd0) ? 10'd999 : 10'((6'd20 - k) * 50);
    endfunction

endpackage

FILE: hw/rtl/touch_selected_led_pattern_generator_top.sv
// ----------------------------------------------------------------------------
// Touch-selected LED pattern generator
// Turns tick and touch tally beats into PWM compare values.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on s_axis carry the tally in tdata and cmd in tuser. A cmd of
//   0 is a PWM period tick, 1 a touch tally sample. Every input beat gives one
//   result beat on m_axis: duty, pattern and touched.
//   Configuration writes on the cfg channel: index 0 sets the touch threshold,
//   index 1 the hold reload; other indexes are ignored. o_cfg_ready is always 1.
//   The result beat is registered and offered in the cycle after its input is
//   taken. One beat per cycle is sustained without stalls: the state update and
//   the table lookup sit in one short combinational pass before the result register.
//   When the receiver stalls, the result register holds and s_axis_tready
//   drops until the result is taken; no beat is lost.
//   Synchronous active-low reset clears pattern and counters, seeds the
//   flicker generator with 13 and level 100, and loads the register
//   defaults (threshold 2000, hold 100).
// ----------------------------------------------------------------------------
module touch_selected_led_pattern_generator_top import tslpg_pkg::*; #(
    parameter int PATTERN_COUNT = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,  // tally[15:0]
    input  logic                  s_axis_tuser,  // cmd[0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,  // duty[9:0], pattern[13:10], touched[14]
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    logic [THR_W-1:0]  r_thr;
    logic [HOLD_W-1:0] r_hold_ticks;
    logic [PAT_W-1:0]  r_pat,  n_pat, w_pat;
    logic [HOLD_W-1:0] r_hold, n_hold, w_hold;
    logic [STEP_W-1:0] r_step, n_step;
    logic [SEED_W-1:0] r_seed, n_seed;
    logic [FLK_W-1:0]  r_flk,  n_flk;
    logic [DUTY_W-1:0] w_duty;
    logic              r_ovalid;
    t_result           r_res;
    t_item             item;
    logic              accept;

    assign item          = '{cmd: s_axis_tuser, tally: s_axis_tdata};
    assign s_axis_tready = !r_ovalid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    tslpg_touch #(.PATTERN_COUNT(PATTERN_COUNT)) u_touch (
        .i_tally_item (item.cmd),
        .i_tally      (item.tally),
        .i_threshold  (r_thr),
        .i_hold_ticks (r_hold_ticks),
        .i_pattern    (r_pat),
        .i_hold       (r_hold),
        .o_pattern    (w_pat),
        .o_hold       (w_hold)
    );

    tslpg_wave u_wave (
        .i_tick    (!item.cmd),
        .i_pattern (r_pat),
        .i_step    (r_step),
        .i_seed    (r_seed),
        .i_flicker (r_flk),
        .o_duty    (w_duty),
        .o_step    (n_step),
        .o_seed    (n_seed),
        .o_flicker (n_flk)
    );

    assign n_pat  = w_pat;
    assign n_hold = w_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr        <= THR_RESET;
            r_hold_ticks <= HOLD_RESET;
            r_pat        <= '0;
            r_hold       <= '0;
            r_step       <= '0;
            r_seed       <= SEED_RESET;
            r_flk        <= FLK_RESET;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_TOUCH_THRESHOLD) r_thr <= i_cfg_data;
                if (i_cfg_index == REG_HOLD_TICKS) r_hold_ticks <= i_cfg_data[HOLD_W-1:0];
            end
            if (accept) begin
                r_pat  <= n_pat;
                r_hold <= n_hold;
                r_step <= n_step;
                r_seed <= n_seed;
                r_flk  <= n_flk;
            end
            if (accept) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= '{duty: w_duty, pattern: n_pat, touched: (n_hold != '0)};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_res.touched, r_res.pattern, r_res.duty};

    a_pat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pat) < PATTERN_COUNT) else $error("pattern out of range");
    a_tally_keeps_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && item.cmd |=> $stable(r_step)) else $error("tally moved step");
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_res.touched == (r_hold != '0)) else $error("touched mismatch");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !m_axis_tready |=> r_ovalid) else $error("result dropped");
endmodule

FILE: hw/rtl/tslpg_touch.sv
// ----------------------------------------------------------------------------
// Touch tracker
// Threshold compare, pattern advance and hold counter next values.
// ----------------------------------------------------------------------------
module tslpg_touch import tslpg_pkg::*; #(
    parameter int PATTERN_COUNT = 10
) (
    input  logic              i_tally_item,
    input  logic [THR_W-1:0]  i_tally,
    input  logic [THR_W-1:0]  i_threshold,
    input  logic [HOLD_W-1:0] i_hold_ticks,
    input  logic [PAT_W-1:0]  i_pattern,
    input  logic [HOLD_W-1:0] i_hold,
    output logic [PAT_W-1:0]  o_pattern,
    output logic [HOLD_W-1:0] o_hold
);
    localparam logic [PAT_W-1:0] LAST_PAT = PAT_W'(PATTERN_COUNT - 1);

    always_comb begin
        o_pattern = i_pattern;
        o_hold    = i_hold;
        if (i_tally_item) begin
            if (i_tally > i_threshold) begin
                if (i_hold == '0) begin
                    o_pattern = (i_pattern >= LAST_PAT) ? '0 : i_pattern + 1'b1;
                end
                o_hold = i_hold_ticks;
            end else if (i_hold != '0) begin
                o_hold = i_hold - 1'b1;
            end
        end
    end
endmodule

FILE: hw/rtl/tslpg_wave.sv
// ----------------------------------------------------------------------------
// Waveform unit
// Duty for a tick, plus step counter and flicker generator next values.
// ----------------------------------------------------------------------------
module tslpg_wave import tslpg_pkg::*; (
    input  logic              i_tick,
    input  logic [PAT_W-1:0]  i_pattern,
    input  logic [STEP_W-1:0] i_step,
    input  logic [SEED_W-1:0] i_seed,
    input  logic [FLK_W-1:0]  i_flicker,
    output logic [DUTY_W-1:0] o_duty,
    output logic [STEP_W-1:0] o_step,
    output logic [SEED_W-1:0] o_seed,
    output logic [FLK_W-1:0]  o_flicker
);
    logic [SEED_W-1:0] seed_nx;
    logic [5:0]        seed_mod;
    logic [9:0]        lvl4;
    logic [FLK_W-1:0]  lvl45;
    logic [FLK_W-1:0]  flk_nx;
    logic [5:0]        s_mod42;
    logic [5:0]        s4_mod42;
    logic [3:0]        s6_mod12;
    logic [5:0]        h_idx;
    logic              adv;

    // Remainder by 42 without a divider: reciprocal multiply then one correction.
    function automatic logic [5:0] mod42(input logic [STEP_W-1:0] v);
        logic [STEP_W+5:0] q;
        logic [STEP_W+5:0] r;
        q = 37'((64'(v) * 64'd3272356035) >> 37);
        r = 37'(v) - q * 37'd42;
        if (r >= 37'd42) r = r - 37'd42;
        return r[5:0];
    endfunction

    // (v / 6) mod 12 equals (v mod 72) / 6; both steps use reciprocal multiplication.
    function automatic logic [3:0] div6mod12(input logic [STEP_W-1:0] v);
        logic [STEP_W-1:0] q;
        logic [6:0]        r;
        q = 31'((64'(v) * 64'd1908874354) >> 37);
        r = 7'(32'(v) - 32'(q) * 32'd72);
        return 4'((16'(r) * 16'd43) >> 8);
    endfunction

    always_comb begin
        seed_nx  = 16'(i_seed * 16'd75 + 16'd74);
        seed_mod = 6'(seed_nx - 16'(32'((32'(seed_nx) * 32'd52429) >> 21)) * 16'd40);
        lvl4     = 10'(i_flicker) << 2;
        lvl45    = 8'(32'((32'(lvl4) * 32'd52429) >> 18));
        flk_nx   = 8'(seed_mod) + lvl45;
        s_mod42  = mod42(i_step);
        s4_mod42 = mod42(i_step >> 2);
        s6_mod12 = div6mod12(i_step);
        h_idx    = 6'(32'(i_step[STEP_W-1:1]) - 32'((64'(i_step[STEP_W-1:1]) * 64'd2863311531)
                   >> 37) * 32'd48);
    end

    always_comb begin
        o_duty    = '0;
        adv       = 1'b1;
        o_seed    = i_seed;
        o_flicker = i_flicker;
        case (i_pattern)
            PAT_SINE:    o_duty = sine_lut(i_step[7:0]);
            PAT_HEART:   o_duty = heart_lut(h_idx);
            PAT_TRI:     o_duty = tri_lut(s_mod42);
            PAT_FLAME: begin
                o_seed    = seed_nx;
                o_flicker = flk_nx;
                o_duty    = 10'(flk_nx);
                adv       = 1'b0;
            end
            PAT_TRIPLE:  o_duty = (s6_mod12 <= 4'd4 && !s6_mod12[0]) ? 10'd990 : 10'd0;
            PAT_LONG:    o_duty = i_step[4] ? 10'd0 : 10'd990;
            PAT_HALFSAW: o_duty = halfsaw_lut(s_mod42);
            PAT_CONST: begin
                o_duty = 10'd500;
                adv    = 1'b0;
            end
            PAT_SLOWTRI: o_duty = tri_lut(s4_mod42);
            default:     adv = 1'b0;
        endcase
        if (!i_tick) begin
            o_duty    = '0;
            adv       = 1'b0;
            o_seed    = i_seed;
            o_flicker = i_flicker;
        end
        o_step = adv ? i_step + 1'b1 : i_step;
    end
endmodule

FILE: tb/tslpg_checker.sv
// ----------------------------------------------------------------------------
// Touch pattern generator checker
// Watches the input, result and configuration channels, predicts each result
// beat from a behavioural copy of the block and compares field by field.
// ----------------------------------------------------------------------------
module tslpg_checker import tslpg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,
    input  logic                  s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [15:0]           m_axis_tdata,
    input  logic                  i_cfg_valid,
    input  logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PATTERN_COUNT = 10;

    logic [THR_W-1:0]  thr;
    logic [HOLD_W-1:0] hold_reload;
    logic [PAT_W-1:0]  pat;
    logic [HOLD_W-1:0] hold;
    logic [STEP_W-1:0] step;
    logic [SEED_W-1:0] seed;
    logic [FLK_W-1:0]  level;
    t_result           expected_q[$];

    int fails;
    assign o_fail_count = fails;
    assign o_pending    = expected_q.size();

    function automatic int ramp_up(input int k);
        return (k >= 20) ? 999 : k * 50;
    endfunction

    logic [9:0] sine_tab [256];
    initial begin
        sine_tab = '{
        10'h1f4,10'h200,10'h20c,10'h218,10'h224,10'h231,10'h23d,10'h249,
        10'h255,10'h261,10'h26d,10'h279,10'h284,10'h290,10'h29c,10'h2a7,
        10'h2b3,10'h2be,10'h2c9,10'h2d4,10'h2df,10'h2ea,10'h2f4,10'h2ff,
        10'h309,10'h313,10'h31d,10'h327,10'h330,10'h33a,10'h343,10'h34c,
        10'h355,10'h35d,10'h366,10'h36e,10'h376,10'h37d,10'h385,10'h38c,
        10'h393,10'h39a,10'h3a0,10'h3a6,10'h3ac,10'h3b2,10'h3b7,10'h3bc,
        10'h3c1,10'h3c6,10'h3ca,10'h3ce,10'h3d1,10'h3d5,10'h3d8,10'h3db,
        10'h3dd,10'h3e0,10'h3e2,10'h3e3,10'h3e5,10'h3e6,10'h3e6,10'h3e7,
        10'h3e7,10'h3e7,10'h3e6,10'h3e6,10'h3e5,10'h3e3,10'h3e2,10'h3e0,
        10'h3dd,10'h3db,10'h3d8,10'h3d5,10'h3d1,10'h3ce,10'h3ca,10'h3c6,
        10'h3c1,10'h3bc,10'h3b7,10'h3b2,10'h3ac,10'h3a6,10'h3a0,10'h39a,
        10'h393,10'h38c,10'h385,10'h37d,10'h376,10'h36e,10'h366,10'h35d,
        10'h355,10'h34c,10'h343,10'h33a,10'h330,10'h327,10'h31d,10'h313,
        10'h309,10'h2ff,10'h2f4,10'h2ea,10'h2df,10'h2d4,10'h2c9,10'h2be,
        10'h2b3,10'h2a7,10'h29c,10'h290,10'h284,10'h279,10'h26d,10'h261,
        10'h255,10'h249,10'h23d,10'h231,10'h224,10'h218,10'h20c,10'h200,
        10'h1f4,10'h1e7,10'h1db,10'h1cf,10'h1c3,10'h1b6,10'h1aa,10'h19e,
        10'h192,10'h186,10'h17a,10'h16e,10'h163,10'h157,10'h14b,10'h140,
        10'h134,10'h129,10'h11e,10'h113,10'h108,10'h0fd,10'h0f3,10'h0e8,
        10'h0de,10'h0d4,10'h0ca,10'h0c0,10'h0b7,10'h0ad,10'h0a4,10'h09b,
        10'h092,10'h08a,10'h081,10'h079,10'h071,10'h06a,10'h062,10'h05b,
        10'h054,10'h04d,10'h047,10'h041,10'h03b,10'h035,10'h030,10'h02b,
        10'h026,10'h021,10'h01d,10'h019,10'h016,10'h012,10'h00f,10'h00c,
        10'h00a,10'h007,10'h005,10'h004,10'h002,10'h001,10'h001,10'h000,
        10'h000,10'h000,10'h001,10'h001,10'h002,10'h004,10'h005,10'h007,
        10'h00a,10'h00c,10'h00f,10'h012,10'h016,10'h019,10'h01d,10'h021,
        10'h026,10'h02b,10'h030,10'h035,10'h03b,10'h041,10'h047,10'h04d,
        10'h054,10'h05b,10'h062,10'h06a,10'h071,10'h079,10'h081,10'h08a,
        10'h092,10'h09b,10'h0a4,10'h0ad,10'h0b7,10'h0c0,10'h0ca,10'h0d4,
        10'h0de,10'h0e8,10'h0f3,10'h0fd,10'h108,10'h113,10'h11e,10'h129,
        10'h134,10'h140,10'h14b,10'h157,10'h163,10'h16e,10'h17a,10'h186,
        10'h192,10'h19e,10'h1aa,10'h1b6,10'h1c3,10'h1cf,10'h1db,10'h1e7};
    end

    function automatic int heart_at(input int k);
        int shape[18] = '{500, 990, 700, 500, 300, 100, 200, 600, 990, 700,
                          500, 400, 300, 250, 200, 150, 100, 50};
        return (k < 18) ? shape[k] : 0;
    endfunction

    function automatic int tri_at(input int k);
        return (k <= 20) ? ramp_up(k) : ramp_up(41 - k);
    endfunction

    function automatic int halfsaw_at(input int k);
        return ramp_up(20 - (k % 21));
    endfunction

    // Advances the predicted state by one beat and returns the result it gives.
    function automatic t_result pattern_step(input logic cmd, input logic [THR_W-1:0] tally);
        t_result r;
        int d;
        logic advance;
        d = 0;
        advance = 1'b0;
        if (cmd) begin
            if (tally > thr) begin
                if (hold == 0)
                    pat = PAT_W'((pat + 1) % PATTERN_COUNT);
                hold = hold_reload;
            end else if (hold != 0) begin
                hold = hold - 1'b1;
            end
        end else begin
            advance = 1'b1;
            case (pat)
                PAT_SINE:    d = sine_tab[step % 256];
                PAT_HEART:   d = heart_at((step / 2) % 48);
                PAT_TRI:     d = tri_at(step % 42);
                PAT_FLAME: begin
                    seed  = SEED_W'(seed * 75 + 74);
                    level = FLK_W'((seed % 40) + (level * 4) / 5);
                    d = level;
                    advance = 1'b0;
                end
                PAT_TRIPLE:  d = (((step / 6) % 12) < 5 && ((step / 6) % 2) == 0) ? 990 : 0;
                PAT_LONG:    d = ((step / 16) % 2 == 0) ? 990 : 0;
                PAT_HALFSAW: d = halfsaw_at(step % 42);
                PAT_CONST: begin
                    d = 500;
                    advance = 1'b0;
                end
                PAT_SLOWTRI: d = tri_at((step / 4) % 42);
                default:     advance = 1'b0;
            endcase
            if (advance)
                step = step + 1'b1;
        end
        r.duty    = DUTY_W'(d);
        r.pattern = pat;
        r.touched = (hold != 0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        fails++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    initial fails = 0;

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            thr = THR_RESET;
            hold_reload = HOLD_RESET;
            pat = '0;
            hold = '0;
            step = '0;
            seed = SEED_RESET;
            level = FLK_RESET;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_TOUCH_THRESHOLD)
                    thr = i_cfg_data;
                else if (i_cfg_index == REG_HOLD_TICKS)
                    hold_reload = i_cfg_data[HOLD_W-1:0];
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.duty    = m_axis_tdata[9:0];
                got.pattern = m_axis_tdata[13:10];
                got.touched = m_axis_tdata[14];
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected beat", m_axis_tdata, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (got.duty != want.duty)
                        report_mismatch("duty", got.duty, want.duty);
                    if (got.pattern != want.pattern)
                        report_mismatch("pattern", got.pattern, want.pattern);
                    if (got.touched != want.touched)
                        report_mismatch("touched", got.touched, want.touched);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(pattern_step(s_axis_tuser, s_axis_tdata));
        end
    end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Touch pattern generator testbench
// Drives tick and tally beats through every pattern under several register
// settings, with random idling on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import tslpg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    // An index that names no register; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd7;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [15:0]           m_axis_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    fail_count;
    int                    pending;
    logic                  steady;      // no idling on either side
    logic                  hold_off;    // long receiver stall
    int                    quiet_cycles;

    touch_selected_led_pattern_generator_top dut (.*);

    tslpg_checker checker_i (.o_fail_count(fail_count), .o_pending(pending), .*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: random stalls, none in a steady stretch, stalled throughout while held off.
    initial m_axis_tready = 1'b0;
    always @(posedge i_clk) begin
        m_axis_tready <= !hold_off && (steady || $urandom_range(99) >= 31);
    end

    initial quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // The beat stays offered after its handshake; the next beat, an idle
    // cycle or a drain takes tvalid over from there.
    task automatic send_beat(input logic cmd, input logic [15:0] tally);
        while (!steady && $urandom_range(99) < 31) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= tally;
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Steps through patterns with well-formed touches and runs of ticks.
    task automatic random_phase(input int n, input logic [15:0] threshold);
        int k;
        logic [15:0] t;
        for (k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0, 1: t = (threshold == 16'hffff) ? 16'hffff
                          : 16'($urandom_range(61440, int'(threshold) + 1));
                2:    t = 16'($urandom_range(threshold));
                3:    t = 16'($urandom);
                default: t = 16'($urandom);
            endcase
            send_beat($urandom_range(9) < 3, t);
        end
    endtask

    initial begin
        int k;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        steady        = 1'b0;
        hold_off      = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: default registers, extremes of tally, touch then release.
        send_beat(1'b0, 16'h0000);
        send_beat(1'b1, 16'd2000);
        send_beat(1'b1, 16'd2001);
        send_beat(1'b1, 16'hffff);
        send_beat(1'b1, 16'h0000);
        send_beat(1'b0, 16'hffff);
        drain();
        // Short hold so that every pattern number up to 9, the unnamed pattern 9 included,
        // is visited with at least one tick each; a zero reload lets touches chain.
        write_reg(REG_HOLD_TICKS, 16'd0);
        write_reg(REG_UNUSED, 16'hffff);
        for (k = 0; k < 11; k++) begin
            send_beat(1'b1, 16'hffff);
            send_beat(1'b0, 16'h5555);
        end
        drain();

        write_reg(REG_TOUCH_THRESHOLD, 16'd0);
        write_reg(REG_HOLD_TICKS, 16'd1);
        steady = 1'b1;
        random_phase(300, 16'd0);
        steady = 1'b0;
        drain();

        write_reg(REG_TOUCH_THRESHOLD, 16'd61440);
        write_reg(REG_HOLD_TICKS, 16'd127);
        random_phase(300, 16'd61440);
        drain();

        write_reg(REG_TOUCH_THRESHOLD, 16'hffff);
        write_reg(REG_HOLD_TICKS, 16'd3);
        random_phase(200, 16'hffff);
        drain();

        // Receiver held off while the sender keeps offering beats.
        write_reg(REG_TOUCH_THRESHOLD, 16'd3000);
        write_reg(REG_HOLD_TICKS, 16'd2);
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end
            random_phase(600, 16'd3000);
        join
        drain();

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
